// ===== rtl/dlr_pkg.sv =====
// Package: shared constants and controller/datapath interface types for dense_label_renumber.
`timescale 1ns / 1ps
`default_nettype none

package dlr_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int LABEL_BITS_DEF  = 32;
    localparam int LABEL_IN_W      = 32;
    localparam int DENSE_W         = 9;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_dlr_cmd;

    typedef struct packed {
        logic resolved;
    } t_dlr_status;

endpackage

`default_nettype wire

// ===== rtl/dense_label_renumber.sv =====
// Top level: dense first-appearance renumbering of a label stream.
//
//  Channel | Handshake                  | Payload
//  --------+----------------------------+-------------------------------------------
//  in      | i_in_valid / o_in_ready    | i_label_in[31:0], i_last_label
//  out     | o_out_valid / i_out_ready  | o_dense_index[8:0], o_is_new, o_overflow
//
// A word is accepted, then scanned against the labels held; a hit ends the scan early,
// while a miss reads every label held before the new label is inserted.
// The single-port table read, one stored label per cycle, paces the scan.
// Reset clears the count and control only; no clearing pass over the table.
// A waiting result does not block acceptance or the scan of the next word;
// only its result write-back waits for the output register to be taken.
`timescale 1ns / 1ps
`default_nettype none

module dense_label_renumber #(
    parameter int TABLE_DEPTH = dlr_pkg::TABLE_DEPTH_DEF,
    parameter int LABEL_BITS  = dlr_pkg::LABEL_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [dlr_pkg::LABEL_IN_W-1:0]  i_label_in,
    input  wire logic                            i_last_label,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [dlr_pkg::DENSE_W-1:0]          o_dense_index,
    output logic                                 o_is_new,
    output logic                                 o_overflow
);

    dlr_pkg::t_dlr_cmd    w_cmd;
    dlr_pkg::t_dlr_status w_status;

    dlr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    dlr_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .LABEL_BITS  (LABEL_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_label_in    (i_label_in),
        .i_last_label  (i_last_label),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_dense_index (o_dense_index),
        .o_is_new      (o_is_new),
        .o_overflow    (o_overflow)
    );

endmodule

`default_nettype wire

// ===== rtl/dlr_ctrl.sv =====
// Controller: sequences accept, table scan and result hand-off.
`timescale 1ns / 1ps
`default_nettype none

module dlr_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire dlr_pkg::t_dlr_status i_status,
    output dlr_pkg::t_dlr_cmd      o_cmd
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.load   = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.finish = 1'b0;
        n_state      = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!i_status.resolved) begin
                    o_cmd.step = 1'b1;
                end else if (w_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = r_out_valid;
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dlr_dpath.sv =====
// Datapath: label table memory, scan pointer, compare stage, count and result word.
`timescale 1ns / 1ps
`default_nettype none

module dlr_dpath #(
    parameter int TABLE_DEPTH = dlr_pkg::TABLE_DEPTH_DEF,
    parameter int LABEL_BITS  = dlr_pkg::LABEL_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [dlr_pkg::LABEL_IN_W-1:0]  i_label_in,
    input  wire logic                            i_last_label,
    input  wire dlr_pkg::t_dlr_cmd               i_cmd,
    output dlr_pkg::t_dlr_status                 o_status,
    output logic [dlr_pkg::DENSE_W-1:0]          o_dense_index,
    output logic                                 o_is_new,
    output logic                                 o_overflow
);

    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int KEEP_W = (LABEL_BITS < dlr_pkg::LABEL_IN_W) ? LABEL_BITS
                                                               : dlr_pkg::LABEL_IN_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    logic [LABEL_BITS-1:0] r_mem [TABLE_DEPTH];

    logic [LABEL_BITS-1:0] r_label;
    logic                  r_last;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [CNT_W-1:0]      r_rd_ptr;
    logic [LABEL_BITS-1:0] r_rd_data;
    logic                  r_cmp_vld;
    logic [ADDR_W-1:0]     r_cmp_pos;
    logic [CNT_W-1:0]      r_idx;
    logic                  r_is_new;
    logic                  r_overflow;

    logic w_rd_en;
    logic w_hit;
    logic w_all_issued;
    logic w_full;
    logic w_insert;

    assign w_rd_en      = i_cmd.step && (r_rd_ptr < r_count);
    assign w_hit        = r_cmp_vld && (r_rd_data == r_label);
    assign w_all_issued = (r_rd_ptr == r_count);
    assign w_full       = (r_count == DEPTH_C);
    assign w_insert     = i_cmd.finish && !w_hit && !w_full;

    // last word in flight is the final compare once every address is issued
    assign o_status.resolved = w_hit || w_all_issued;

    always_comb begin
        n_count = r_count;
        if (i_cmd.finish) begin
            if (w_insert) begin
                n_count = r_count + ONE_C;
            end
            if (r_last) begin
                n_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_rd_ptr[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_insert) begin
            r_mem[r_count[ADDR_W-1:0]] <= r_label;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_label  <= LABEL_BITS'(i_label_in[KEEP_W-1:0]);
            r_last   <= i_last_label;
            r_rd_ptr <= '0;
        end else if (w_rd_en) begin
            r_rd_ptr  <= r_rd_ptr + ONE_C;
            r_cmp_pos <= r_rd_ptr[ADDR_W-1:0];
        end
        if (i_cmd.finish) begin
            if (w_hit) begin
                r_idx      <= CNT_W'({1'b0, r_cmp_pos}) + ONE_C;
                r_is_new   <= 1'b0;
                r_overflow <= 1'b0;
            end else if (!w_full) begin
                r_idx      <= r_count + ONE_C;
                r_is_new   <= 1'b1;
                r_overflow <= 1'b0;
            end else begin
                r_idx      <= '0;
                r_is_new   <= 1'b0;
                r_overflow <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.load || i_cmd.finish) begin
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.step) begin
                r_cmp_vld <= w_rd_en;
            end
        end
    end

    assign o_dense_index = dlr_pkg::DENSE_W'(r_idx);
    assign o_is_new      = r_is_new;
    assign o_overflow    = r_overflow;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("table count beyond depth");

    a_cmp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> (CNT_W'({1'b0, r_cmp_pos}) < r_count))
        else $error("compare of an entry beyond the count");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_insert && !r_last) |=> (r_count == $past(r_count) + ONE_C))
        else $error("insert did not grow the count");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && r_last) |=> (r_count == '0))
        else $error("last word of set did not clear the count");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for dense_label_renumber: randomised label sets checked against a behavioural table.
`timescale 1ns / 1ps

module tb;

    localparam int TABLE_DEPTH    = dlr_pkg::TABLE_DEPTH_DEF;
    localparam int N_ITEMS        = 1050;
    localparam int HOLD_LEN       = 1500;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 300;

    typedef logic [dlr_pkg::DENSE_W-1:0]    t_dense;
    typedef logic [dlr_pkg::LABEL_IN_W-1:0] t_label;

    typedef struct packed {
        t_dense idx;
        logic   fresh;
        logic   ovf;
    } t_dense_res;

    typedef struct packed {
        t_label label;
        logic   last;
    } t_label_word;

    logic   i_clk         = 1'b0;
    logic   i_rst_n       = 1'b0;
    logic   i_in_valid    = 1'b0;
    t_label i_label_in    = '0;
    logic   i_last_label  = 1'b0;
    logic   i_out_ready   = 1'b0;
    logic   o_in_ready;
    logic   o_out_valid;
    t_dense o_dense_index;
    logic   o_is_new;
    logic   o_overflow;

    t_label_word label_q[$];
    t_dense_res  dense_q[$];
    t_label      held_labels[TABLE_DEPTH];
    int          held_count  = 0;
    int          n_total     = N_ITEMS;
    int          n_sent      = 0;
    int          n_recv      = 0;
    int          n_err       = 0;
    int          hold_left   = 0;
    int          last_hold   = -1;
    int          idle_cycles = 0;

    dense_label_renumber i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_label_in    (i_label_in),
        .i_last_label  (i_last_label),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_dense_index (o_dense_index),
        .o_is_new      (o_is_new),
        .o_overflow    (o_overflow)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_dense_res renumber_label(input t_label lbl, input logic last);
        t_dense_res r;
        bit         found;
        r = '0;
        found = 0;
        for (int p = 0; p < held_count; p++) begin
            if (!found && held_labels[p] == lbl) begin
                found = 1;
                r.idx = t_dense'(p + 1);
            end
        end
        if (!found) begin
            if (held_count < TABLE_DEPTH) begin
                held_labels[held_count] = lbl;
                held_count++;
                r.idx   = t_dense'(held_count);
                r.fresh = 1'b1;
            end else begin
                r.ovf = 1'b1;
            end
        end
        if (last)
            held_count = 0;
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin : drv
        logic acc;
        logic hold;
        logic nv;
        int   pct;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            acc  = i_in_valid && o_in_ready;
            hold = i_in_valid && !acc;
            if (acc) begin
                dense_q.push_back(renumber_label(i_label_in, i_last_label));
                void'(label_q.pop_front());
                n_sent++;
            end
            pct = (n_sent * 3 < n_total) ? 33 : (n_sent * 3 < 2 * n_total) ? 57 : 0;
            if (hold)
                nv = 1'b1;
            else
                nv = (label_q.size() != 0) && ($urandom_range(99) >= pct);
            if (nv && !hold) begin
                i_label_in   <= label_q[0].label;
                i_last_label <= label_q[0].last;
            end
            i_in_valid <= nv;
        end
    end

    // monitor
    always @(posedge i_clk) begin : mon
        t_dense_res exp_r;
        logic       rdy;
        int         pct;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (dense_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("unexpected word: idx=%0d new=%0b ovf=%0b",
                                 o_dense_index, o_is_new, o_overflow);
                end else begin
                    exp_r = dense_q.pop_front();
                    if (o_dense_index !== exp_r.idx || o_is_new !== exp_r.fresh ||
                        o_overflow !== exp_r.ovf) begin
                        n_err++;
                        if (n_err <= 10)
                            $display({"word %0d: exp idx=%0d new=%0b ovf=%0b, ",
                                      "got idx=%0d new=%0b ovf=%0b"},
                                     n_recv, exp_r.idx, exp_r.fresh, exp_r.ovf,
                                     o_dense_index, o_is_new, o_overflow);
                    end
                end
                n_recv++;
            end
            pct = (n_recv * 3 < n_total) ? 57 : (n_recv * 3 < 2 * n_total) ? 33 : 0;
            if (hold_left == 0 && (n_recv == 40 || n_recv == 900) && n_recv != last_hold) begin
                last_hold = n_recv;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                rdy = ($urandom_range(99) >= pct);
            end
            i_out_ready <= rdy;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb NOT OK");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : stim
        t_label_word w;
        t_label      pool[24];
        int          pool_n;
        int          set_len;
        t_label      d[$];
        t_label      dl[$];

        // directed: extremes, hits, last on hit, last on insert, single-word sets
        d  = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
               32'h5555_5555, 32'h5555_5555, 32'h5555_5555, 32'h0000_0000, 32'h0000_0000,
               32'h8000_0000, 32'h0000_0001, 32'h8000_0000, 32'h1234_5678, 32'h1234_5678};
        dl = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd1, 32'd0,
               32'd0, 32'd0, 32'd1, 32'd1, 32'd1};
        foreach (d[k]) begin
            w.label = d[k];
            w.last  = dl[k][0];
            label_q.push_back(w);
        end

        // full table, then new labels while full, hits at both ends, last on overflow
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            w.label = {24'($urandom()), 8'(k)};
            w.last  = 1'b0;
            label_q.push_back(w);
        end
        w.last = 1'b0;
        for (int k = 0; k < 3; k++) begin
            w.label = $urandom();
            label_q.push_back(w);
        end
        label_q.push_back(label_q[label_q.size() - 4]);
        label_q.push_back(label_q[d.size()]);
        w.label = $urandom();
        w.last  = 1'b1;
        label_q.push_back(w);

        while (label_q.size() < N_ITEMS) begin
            pool_n  = $urandom_range(24, 1);
            for (int k = 0; k < pool_n; k++)
                pool[k] = $urandom();
            set_len = ($urandom_range(9) == 0) ? $urandom_range(120, 40)
                                               : $urandom_range(30, 1);
            for (int k = 0; k < set_len; k++) begin
                w.label = ($urandom_range(9) == 0) ? t_label'($urandom())
                                                   : pool[$urandom_range(pool_n - 1)];
                w.last  = (k == set_len - 1);
                label_q.push_back(w);
            end
        end
        n_total = label_q.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (label_q.size() != 0 || dense_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_err == 0 && dense_q.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
